>>> sv/qrs_pkg.sv
// Shared constants and types for the quadratic root solver.
package qrs_pkg;

  localparam int unsigned COEFF_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    KIND_TWO_REAL = 2'd0,
    KIND_DOUBLE   = 2'd1,
    KIND_COMPLEX  = 2'd2,
    KIND_NOT_QUAD = 2'd3
  } root_kind_e;

endpackage

>>> sv/qrs_in_if.sv
// Coefficient channel: valid/ready handshake carrying a, b and c.
interface qrs_in_if import qrs_pkg::*; #(
  parameter int unsigned COEFF_BITS = COEFF_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COEFF_BITS-1:0] coeff_a;
  logic signed [COEFF_BITS-1:0] coeff_b;
  logic signed [COEFF_BITS-1:0] coeff_c;

  modport source (output valid, output coeff_a, output coeff_b, output coeff_c, input ready);
  modport sink   (input valid, input coeff_a, input coeff_b, input coeff_c, output ready);
endinterface

>>> sv/qrs_out_if.sv
// Root channel: valid/ready handshake carrying root kind and fixed point roots.
interface qrs_out_if import qrs_pkg::*; #(
  parameter int unsigned OUT_BITS = COEFF_BITS_DEF + FRAC_BITS_DEF + 2
);
  logic                       valid;
  logic                       ready;
  logic [1:0]                 root_kind;
  logic signed [OUT_BITS-1:0] first_real;
  logic signed [OUT_BITS-1:0] second_real;
  logic signed [OUT_BITS-1:0] imag_part;

  modport source (output valid, output root_kind, output first_real, output second_real,
                  output imag_part, input ready);
  modport sink   (input valid, input root_kind, input first_real, input second_real,
                  input imag_part, output ready);
endinterface

>>> sv/qrs_disc.sv
// Discriminant stages: products, then b*b - 4ac with classification.
module qrs_disc import qrs_pkg::*; #(
  parameter int unsigned COEFF_BITS = COEFF_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  localparam int unsigned DW  = 2 * COEFF_BITS + 1,
  localparam int unsigned NW  = COEFF_BITS + FRAC_BITS + 2,
  localparam int unsigned DVW = COEFF_BITS + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [COEFF_BITS-1:0] a_i,
  input  logic signed [COEFF_BITS-1:0] b_i,
  input  logic signed [COEFF_BITS-1:0] c_i,
  output logic                         valid_o,
  output logic [DW-1:0]                disc_o,
  output root_kind_e                   kind_o,
  output logic [NW-1:0]                nb_o,
  output logic [DVW-1:0]               den_mag_o,
  output logic                         den_neg_o
);

  logic [COEFF_BITS-1:0] a_mag, b_mag, c_mag;

  logic                    vld1_q;
  logic [2*COEFF_BITS-1:0] bb_q, ac_q;
  logic                    a_neg_q, c_neg_q, a_zero_q, c_zero_q;
  logic [COEFF_BITS-1:0]   a_mag_q;
  logic [COEFF_BITS-1:0]   b_q;

  logic [DW:0]      bb_x, ac4_x, d_x;
  logic             dneg;
  root_kind_e       kind_d;
  logic [NW-1:0]    b_ext;

  logic             vld2_q;
  logic [DW-1:0]    disc_q;
  root_kind_e       kind_q;
  logic [NW-1:0]    nb_q;
  logic [DVW-1:0]   den_mag_q;
  logic             den_neg_q;

  assign a_mag = a_i[COEFF_BITS-1] ? (~a_i + 1'b1) : a_i;
  assign b_mag = b_i[COEFF_BITS-1] ? (~b_i + 1'b1) : b_i;
  assign c_mag = c_i[COEFF_BITS-1] ? (~c_i + 1'b1) : c_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bb_q     <= b_mag * b_mag;
      ac_q     <= a_mag * c_mag;
      a_neg_q  <= a_i[COEFF_BITS-1];
      c_neg_q  <= c_i[COEFF_BITS-1];
      a_zero_q <= (a_mag == '0);
      c_zero_q <= (c_mag == '0);
      a_mag_q  <= a_mag;
      b_q      <= b_i;
    end
  end

  always_comb begin
    bb_x  = {2'b00, bb_q};
    ac4_x = {ac_q, 2'b00};
    dneg  = 1'b0;
    if (c_zero_q || (a_neg_q != c_neg_q)) begin
      d_x = bb_x + ac4_x;
    end else if (bb_x >= ac4_x) begin
      d_x = bb_x - ac4_x;
    end else begin
      d_x  = ac4_x - bb_x;
      dneg = 1'b1;
    end
    priority if (a_zero_q) kind_d = KIND_NOT_QUAD;
    else if (d_x == '0)    kind_d = KIND_DOUBLE;
    else if (dneg)         kind_d = KIND_COMPLEX;
    else                   kind_d = KIND_TWO_REAL;
    b_ext = {{(NW-COEFF_BITS){b_q[COEFF_BITS-1]}}, b_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      disc_q    <= d_x[DW-1:0];
      kind_q    <= kind_d;
      nb_q      <= (~b_ext + 1'b1) << FRAC_BITS;
      den_mag_q <= {a_mag_q, 1'b0};
      den_neg_q <= a_neg_q;
    end
  end

  assign valid_o   = vld2_q;
  assign disc_o    = disc_q;
  assign kind_o    = kind_q;
  assign nb_o      = nb_q;
  assign den_mag_o = den_mag_q;
  assign den_neg_o = den_neg_q;

endmodule

>>> sv/qrs_sqrt.sv
// Pipelined floor square root, one root bit per stage.
module qrs_sqrt #(
  parameter int unsigned SW     = 33,
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*SW-1:0]   rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [SW-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_q  [SW];
  logic [SW+1:0]     rem_q  [SW];
  logic [SW-1:0]     root_q [SW];
  logic [2*SW-1:0]   rad_q  [SW];
  logic [SIDE_W-1:0] side_q [SW];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic              vld_in;
    logic [SW+1:0]     rem_in;
    logic [SW-1:0]     root_in;
    logic [2*SW-1:0]   rad_in;
    logic [SIDE_W-1:0] side_in;
    logic [SW+3:0]     sh, trial;
    logic [SW+1:0]     rem_nx;
    logic              bit_nx;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      sh    = {rem_in, rad_in[2*SW-1 -: 2]};
      trial = {2'b00, root_in, 2'b01};
      if (sh >= trial) begin
        rem_nx = (SW+2)'(sh - trial);
        bit_nx = 1'b1;
      end else begin
        rem_nx = sh[SW+1:0];
        bit_nx = 1'b0;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_nx;
        root_q[k] <= {root_in[SW-2:0], bit_nx};
        rad_q[k]  <= {rad_in[2*SW-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[SW-1];
  assign root_o  = root_q[SW-1];
  assign side_o  = side_q[SW-1];

endmodule

>>> sv/qrs_div.sv
// Pipelined restoring divider, several numerator lanes over a shared divisor.
module qrs_div #(
  parameter int unsigned NW     = 34,
  parameter int unsigned DVW    = 17,
  parameter int unsigned LANES  = 3,
  parameter int unsigned SIDE_W = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [LANES-1:0][NW-1:0]   num_i,
  input  logic [DVW-1:0]             den_mag_i,
  input  logic                       den_neg_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  output logic [LANES-1:0][NW-1:0]   quot_o,
  output logic [LANES-1:0]           neg_o,
  output logic [SIDE_W-1:0]          side_o
);

  logic                        vld_q  [NW];
  logic [LANES-1:0][NW-1:0]    work_q [NW];
  logic [LANES-1:0][DVW-1:0]   rem_q  [NW];
  logic [LANES-1:0]            neg_q  [NW];
  logic [DVW-1:0]              dv_q   [NW];
  logic [SIDE_W-1:0]           side_q [NW];

  logic [LANES-1:0][NW-1:0]    num_mag;
  logic [LANES-1:0]            num_neg;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num_neg[l] = num_i[l][NW-1] ^ den_neg_i;
      num_mag[l] = num_i[l][NW-1] ? (~num_i[l] + 1'b1) : num_i[l];
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic                       vld_in;
    logic [LANES-1:0][NW-1:0]   work_in, work_nx;
    logic [LANES-1:0][DVW-1:0]  rem_in, rem_nx;
    logic [LANES-1:0]           neg_in;
    logic [DVW-1:0]             dv_in;
    logic [SIDE_W-1:0]          side_in;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign work_in = num_mag;
      assign rem_in  = '0;
      assign neg_in  = num_neg;
      assign dv_in   = den_mag_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign work_in = work_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign neg_in  = neg_q[k-1];
      assign dv_in   = dv_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      logic [DVW:0] sh;
      logic [DVW:0] diff;
      for (int l = 0; l < LANES; l++) begin
        sh   = {rem_in[l], work_in[l][NW-1]};
        diff = sh - {1'b0, dv_in};
        if (sh >= {1'b0, dv_in}) begin
          rem_nx[l]  = diff[DVW-1:0];
          work_nx[l] = {work_in[l][NW-2:0], 1'b1};
        end else begin
          rem_nx[l]  = sh[DVW-1:0];
          work_nx[l] = {work_in[l][NW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        work_q[k] <= work_nx;
        rem_q[k]  <= rem_nx;
        neg_q[k]  <= neg_in;
        dv_q[k]   <= dv_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quot_o  = work_q[NW-1];
  assign neg_o   = neg_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

>>> sv/quadratic_root_solver.sv
// Quadratic root solver: pipelined discriminant, square root and division.
// Usage: coefficients a, b, c arrive on coeff_i as one beat; each beat gives
// exactly one beat on root_o, in order. root_kind says two real roots, a
// double root, a complex pair (imag_part is the first root's imaginary part,
// the second has its negation) or not quadratic (a zero, all roots zero).
// Roots are signed fixed point with FRAC_BITS fraction bits, quotients
// truncated toward zero, square root floored.
// Throughput: one beat per cycle while root_o takes its beats.
// Pipeline, in order: two discriminant stages, the bit-per-stage square
// root (COEFF_BITS+FRAC_BITS+1 stages), a numerator stage, the bit-per-stage
// divider (COEFF_BITS+FRAC_BITS+2 stages) and the output register.
// Stall: the whole pipeline holds while root_o has a beat that is not taken;
// coeff_i.ready is low only then, and no beat is lost or repeated.
// Reset: rst_ni clears every stage's valid bit at once; the block is ready
// as soon as reset is released.
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int unsigned COEFF_BITS = COEFF_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qrs_in_if.sink     coeff_i,
  qrs_out_if.source  root_o
);

  localparam int unsigned DW     = 2 * COEFF_BITS + 1;
  localparam int unsigned SW     = COEFF_BITS + FRAC_BITS + 1;
  localparam int unsigned NW     = COEFF_BITS + FRAC_BITS + 2;
  localparam int unsigned DVW    = COEFF_BITS + 1;
  localparam int unsigned SIDE_W = 2 + NW + 1 + DVW;

  function automatic logic [NW-1:0] sat_q(input logic [NW-1:0] mag, input logic neg);
    logic [NW-1:0] lim;
    logic [NW-1:0] m;
    lim = {1'b1, {(NW-1){1'b0}}};
    m   = mag;
    if (neg) begin
      if (m > lim) m = lim;
      sat_q = ~m + 1'b1;
    end else begin
      if (m > lim - 1'b1) m = lim - 1'b1;
      sat_q = m;
    end
  endfunction

  logic en;

  // discriminant
  logic           d_vld;
  logic [DW-1:0]  d_disc;
  root_kind_e     d_kind;
  logic [NW-1:0]  d_nb;
  logic [DVW-1:0] d_den_mag;
  logic           d_den_neg;

  // square root
  logic              s_vld;
  logic [SW-1:0]     s_root;
  logic [SIDE_W-1:0] s_side;
  logic [1:0]        s_kind;
  logic [NW-1:0]     s_nb, s_ext, s_diff, s_sum, s_negr;
  logic [DVW-1:0]    s_den_mag;
  logic              s_den_neg;

  // numerators
  logic                     num_vld_q;
  logic [2:0][NW-1:0]       num_q;
  logic [DVW-1:0]           den_mag_q;
  logic                     den_neg_q;
  logic [1:0]               num_kind_q;

  // division
  logic               q_vld;
  logic [2:0][NW-1:0] q_mag;
  logic [2:0]         q_neg;
  logic [1:0]         q_kind;

  // output register
  logic          out_vld_q;
  logic [1:0]    out_kind_q;
  logic [NW-1:0] out_r1_q, out_r2_q, out_im_q;

  assign en            = !out_vld_q || root_o.ready;
  assign coeff_i.ready = en;

  qrs_disc #(
    .COEFF_BITS (COEFF_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_disc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (coeff_i.valid),
    .a_i       (coeff_i.coeff_a),
    .b_i       (coeff_i.coeff_b),
    .c_i       (coeff_i.coeff_c),
    .valid_o   (d_vld),
    .disc_o    (d_disc),
    .kind_o    (d_kind),
    .nb_o      (d_nb),
    .den_mag_o (d_den_mag),
    .den_neg_o (d_den_neg)
  );

  qrs_sqrt #(
    .SW     (SW),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_vld),
    .rad_i   ({1'b0, d_disc, {(2*FRAC_BITS){1'b0}}}),
    .side_i  ({d_kind, d_nb, d_den_neg, d_den_mag}),
    .valid_o (s_vld),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  assign {s_kind, s_nb, s_den_neg, s_den_mag} = s_side;
  assign s_ext  = {1'b0, s_root};
  assign s_diff = s_nb - s_ext;
  assign s_sum  = s_nb + s_ext;
  assign s_negr = ~s_ext + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vld_q <= 1'b0;
    end else if (en) begin
      num_vld_q <= s_vld;
    end
  end

  // complex pair shares the real part; only it has an imaginary numerator
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (s_kind == KIND_COMPLEX) begin
        num_q <= {s_negr, s_nb, s_nb};
      end else begin
        num_q <= {{NW{1'b0}}, s_sum, s_diff};
      end
      den_mag_q  <= s_den_mag;
      den_neg_q  <= s_den_neg;
      num_kind_q <= s_kind;
    end
  end

  qrs_div #(
    .NW     (NW),
    .DVW    (DVW),
    .LANES  (3),
    .SIDE_W (2)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (num_vld_q),
    .num_i     (num_q),
    .den_mag_i (den_mag_q),
    .den_neg_i (den_neg_q),
    .side_i    (num_kind_q),
    .valid_o   (q_vld),
    .quot_o    (q_mag),
    .neg_o     (q_neg),
    .side_o    (q_kind)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= q_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_kind_q <= q_kind;
      if (q_kind == KIND_NOT_QUAD) begin
        out_r1_q <= '0;
        out_r2_q <= '0;
        out_im_q <= '0;
      end else begin
        out_r1_q <= sat_q(q_mag[0], q_neg[0]);
        out_r2_q <= sat_q(q_mag[1], q_neg[1]);
        out_im_q <= sat_q(q_mag[2], q_neg[2]);
      end
    end
  end

  assign root_o.valid       = out_vld_q;
  assign root_o.root_kind   = out_kind_q;
  assign root_o.first_real  = out_r1_q;
  assign root_o.second_real = out_r2_q;
  assign root_o.imag_part   = out_im_q;

endmodule
